>>> design/gmbt_pkg.sv
// ============================================================================
// gmbt_pkg
// Shared types, constants and helpers for the grid block mean threshold block.
// ============================================================================
package gmbt_pkg;

    localparam int MAX_IMAGE_DIM_DEF     = 4096;
    localparam int MAX_BLOCKS_ACROSS_DEF = 16;
    localparam int MAX_BLOCKS_DOWN_DEF   = 16;

    localparam int DIM_REG_W  = 13;
    localparam int GRID_REG_W = 5;
    localparam int CUTOFF_W   = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CHAN_W     = 8;
    localparam int PIX_SUM_W  = 10;
    localparam int INDEX_W    = 8;
    localparam int BX_W       = 6;   // holds a block column index up to 63

    localparam int RESET_IMAGE_WIDTH   = 640;
    localparam int RESET_IMAGE_HEIGHT  = 480;
    localparam int RESET_BLOCKS_ACROSS = 10;
    localparam int RESET_BLOCKS_DOWN   = 8;
    localparam int RESET_CUTOFF        = 0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_BLOCKS_ACROSS = 3'd2,
        CFG_BLOCKS_DOWN   = 3'd3,
        CFG_CUTOFF        = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic              frame_start;
        logic [CHAN_W-1:0] chan_a;
        logic [CHAN_W-1:0] chan_b;
        logic [CHAN_W-1:0] chan_c;
    } t_pix_in;

    typedef struct packed {
        logic               bit_value;
        logic [INDEX_W-1:0] block_index;
        logic               last_block;
    } t_bit_out;

    // one classified pixel, front to back
    typedef struct packed {
        logic                 frame_start;
        logic                 acc;
        logic                 emit;
        logic [BX_W-1:0]      bx;
        logic [PIX_SUM_W-1:0] pix;
        logic [INDEX_W-1:0]   block_index;
        logic                 last_block;
    } t_item;

    typedef struct packed {
        logic ready;   // latched geometry matches the registers
        logic done;    // one-cycle pulse when a new result lands
    } t_geom_status;

    // zero reads as one, oversize saturates
    function automatic int clamp_range(int v, int hi);
        int r;
        r = v;
        if (v == 0) begin
            r = 1;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

>>> design/gmbt_stream_if.sv
// ============================================================================
// gmbt_stream_if
// Valid/ready stream channel carrying one payload per request.
// ============================================================================
interface gmbt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/gmbt_geom.sv
// ============================================================================
// gmbt_geom
// Configuration registers and the frame geometry unit: block size by
// iterative division, then the decision level by two registered multiplies.
// ============================================================================
module gmbt_geom #(
    parameter int MAX_IMAGE_DIM     = gmbt_pkg::MAX_IMAGE_DIM_DEF,
    parameter int MAX_BLOCKS_ACROSS = gmbt_pkg::MAX_BLOCKS_ACROSS_DEF,
    parameter int MAX_BLOCKS_DOWN   = gmbt_pkg::MAX_BLOCKS_DOWN_DEF,
    localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1),
    localparam int GX_W  = $clog2(MAX_BLOCKS_ACROSS + 1),
    localparam int GY_W  = $clog2(MAX_BLOCKS_DOWN + 1),
    localparam int LEV_W = gmbt_pkg::CUTOFF_W + 2 * DIM_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gmbt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [gmbt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output gmbt_pkg::t_geom_status          o_status,
    output logic [DIM_W-1:0]                o_fw,
    output logic [DIM_W-1:0]                o_bw,
    output logic [DIM_W-1:0]                o_bh,
    output logic [GX_W-1:0]                 o_gx,
    output logic [GY_W-1:0]                 o_gy,
    output logic [LEV_W-1:0]                o_level
);
    import gmbt_pkg::*;

    localparam int CNT_W  = $clog2(DIM_W + 1);
    localparam int PROD_W = CUTOFF_W + DIM_W;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL1, ST_MUL2} t_state;

    t_state                r_state;
    logic                  r_dirty;
    logic                  r_done;
    logic [DIM_REG_W-1:0]  r_cfg_w;
    logic [DIM_REG_W-1:0]  r_cfg_h;
    logic [GRID_REG_W-1:0] r_cfg_gx;
    logic [GRID_REG_W-1:0] r_cfg_gy;
    logic [CUTOFF_W-1:0]   r_cfg_cut;

    // snapshot taken when a computation starts
    logic [DIM_W-1:0]    r_fw, r_fh;
    logic [GX_W-1:0]     r_gx;
    logic [GY_W-1:0]     r_gy;
    logic [CUTOFF_W-1:0] r_cut;

    logic [DIM_W-1:0]  r_nw, r_nh, r_qw, r_qh, r_rw, r_rh;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_prod;

    logic [DIM_W:0] n_sw, n_sh;
    logic           n_bw, n_bh;

    always_comb begin
        n_sw = {r_rw, r_nw[DIM_W-1]};
        n_sh = {r_rh, r_nh[DIM_W-1]};
        n_bw = (n_sw >= (DIM_W+1)'(r_gx));
        n_bh = (n_sh >= (DIM_W+1)'(r_gy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_DIV;
            r_dirty   <= 1'b0;
            r_done    <= 1'b0;
            r_cfg_w   <= DIM_REG_W'(RESET_IMAGE_WIDTH);
            r_cfg_h   <= DIM_REG_W'(RESET_IMAGE_HEIGHT);
            r_cfg_gx  <= GRID_REG_W'(RESET_BLOCKS_ACROSS);
            r_cfg_gy  <= GRID_REG_W'(RESET_BLOCKS_DOWN);
            r_cfg_cut <= CUTOFF_W'(RESET_CUTOFF);
            r_fw      <= DIM_W'(clamp_range(RESET_IMAGE_WIDTH, MAX_IMAGE_DIM));
            r_fh      <= DIM_W'(clamp_range(RESET_IMAGE_HEIGHT, MAX_IMAGE_DIM));
            r_gx      <= GX_W'(clamp_range(RESET_BLOCKS_ACROSS, MAX_BLOCKS_ACROSS));
            r_gy      <= GY_W'(clamp_range(RESET_BLOCKS_DOWN, MAX_BLOCKS_DOWN));
            r_cut     <= CUTOFF_W'(RESET_CUTOFF);
            r_nw      <= DIM_W'(clamp_range(RESET_IMAGE_WIDTH, MAX_IMAGE_DIM));
            r_nh      <= DIM_W'(clamp_range(RESET_IMAGE_HEIGHT, MAX_IMAGE_DIM));
            r_qw      <= '0;
            r_qh      <= '0;
            r_rw      <= '0;
            r_rh      <= '0;
            r_cnt     <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (r_dirty) begin
                        r_dirty <= 1'b0;
                        r_fw    <= DIM_W'(clamp_range(int'(r_cfg_w), MAX_IMAGE_DIM));
                        r_fh    <= DIM_W'(clamp_range(int'(r_cfg_h), MAX_IMAGE_DIM));
                        r_gx    <= GX_W'(clamp_range(int'(r_cfg_gx), MAX_BLOCKS_ACROSS));
                        r_gy    <= GY_W'(clamp_range(int'(r_cfg_gy), MAX_BLOCKS_DOWN));
                        r_cut   <= r_cfg_cut;
                        r_nw    <= DIM_W'(clamp_range(int'(r_cfg_w), MAX_IMAGE_DIM));
                        r_nh    <= DIM_W'(clamp_range(int'(r_cfg_h), MAX_IMAGE_DIM));
                        r_qw    <= '0;
                        r_qh    <= '0;
                        r_rw    <= '0;
                        r_rh    <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // restoring division, one quotient bit of each per cycle
                    r_rw  <= n_bw ? DIM_W'(n_sw - (DIM_W+1)'(r_gx)) : DIM_W'(n_sw);
                    r_rh  <= n_bh ? DIM_W'(n_sh - (DIM_W+1)'(r_gy)) : DIM_W'(n_sh);
                    r_qw  <= {r_qw[DIM_W-2:0], n_bw};
                    r_qh  <= {r_qh[DIM_W-2:0], n_bh};
                    r_nw  <= r_nw << 1;
                    r_nh  <= r_nh << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIM_W - 1)) begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_prod  <= PROD_W'(r_cut) * PROD_W'(r_qw);
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    o_level <= LEV_W'(r_prod) * LEV_W'(r_qh);
                    o_fw    <= r_fw;
                    o_bw    <= r_qw;
                    o_bh    <= r_qh;
                    o_gx    <= r_gx;
                    o_gy    <= r_gy;
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                r_dirty <= 1'b1;
                case (t_cfg_index'(i_cfg_addr))
                    CFG_IMAGE_WIDTH:   r_cfg_w   <= i_cfg_data;
                    CFG_IMAGE_HEIGHT:  r_cfg_h   <= i_cfg_data;
                    CFG_BLOCKS_ACROSS: r_cfg_gx  <= i_cfg_data[GRID_REG_W-1:0];
                    CFG_BLOCKS_DOWN:   r_cfg_gy  <= i_cfg_data[GRID_REG_W-1:0];
                    CFG_CUTOFF:        r_cfg_cut <= i_cfg_data[CUTOFF_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_status.ready = (r_state == ST_IDLE) && !r_dirty;
    assign o_status.done  = r_done;

    a_cfg_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_status.ready)
        else $error("geometry reported ready right after a config write");

    a_div_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ((32'(o_bw) * 32'(o_gx) <= 32'(o_fw)) &&
                    (32'(o_fw) < (32'(o_bw) + 32'd1) * 32'(o_gx))))
        else $error("block width is not the floor of width over blocks");

endmodule

>>> design/gmbt_front.sv
// ============================================================================
// gmbt_front
// Accepts pixels, tracks the raster position against the latched geometry
// and classifies each pixel into its block column for the back end.
// ============================================================================
module gmbt_front #(
    parameter int MAX_IMAGE_DIM     = gmbt_pkg::MAX_IMAGE_DIM_DEF,
    parameter int MAX_BLOCKS_ACROSS = gmbt_pkg::MAX_BLOCKS_ACROSS_DEF,
    parameter int MAX_BLOCKS_DOWN   = gmbt_pkg::MAX_BLOCKS_DOWN_DEF,
    localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1),
    localparam int GX_W  = $clog2(MAX_BLOCKS_ACROSS + 1),
    localparam int GY_W  = $clog2(MAX_BLOCKS_DOWN + 1),
    localparam int LEV_W = gmbt_pkg::CUTOFF_W + 2 * DIM_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    gmbt_stream_if.sink            i_pix,
    input  gmbt_pkg::t_geom_status i_status,
    input  logic [DIM_W-1:0]       i_fw,
    input  logic [DIM_W-1:0]       i_bw,
    input  logic [DIM_W-1:0]       i_bh,
    input  logic [GX_W-1:0]        i_gx,
    input  logic [GY_W-1:0]        i_gy,
    input  logic [LEV_W-1:0]       i_level,
    input  logic                   i_q_full,
    output logic                   o_push,
    output gmbt_pkg::t_item        o_item,
    output logic [LEV_W-1:0]       o_level
);
    import gmbt_pkg::*;

    logic               r_boot;
    logic [DIM_W-1:0]   r_fw, r_bw, r_bh;
    logic [GX_W-1:0]    r_gx;
    logic [GY_W-1:0]    r_gy;
    logic [LEV_W-1:0]   r_level;
    logic [DIM_W-1:0]   r_col, r_cx, r_ry;
    logic [GX_W-1:0]    r_bx;
    logic [GY_W-1:0]    r_by;
    logic [INDEX_W-1:0] r_base;

    logic               fs, take;
    logic [DIM_W-1:0]   g_fw, g_bw, g_bh, col, cx, ry;
    logic [GX_W-1:0]    g_gx, bx;
    logic [GY_W-1:0]    g_gy, by;
    logic [INDEX_W-1:0] base;
    logic               in_region, cx_end, ry_end;
    logic [DIM_W-1:0]   n_col, n_cx, n_ry;
    logic [GX_W-1:0]    n_bx;
    logic [GY_W-1:0]    n_by;
    logic [INDEX_W-1:0] n_base;

    assign i_pix.ready = !r_boot && i_status.ready && !i_q_full;
    assign take        = i_pix.valid && i_pix.ready;
    assign fs          = i_pix.data.frame_start;

    always_comb begin
        // a frame start pixel already uses the freshly latched geometry
        g_fw = fs ? i_fw : r_fw;
        g_bw = fs ? i_bw : r_bw;
        g_bh = fs ? i_bh : r_bh;
        g_gx = fs ? i_gx : r_gx;
        g_gy = fs ? i_gy : r_gy;
        col  = fs ? '0 : r_col;
        cx   = fs ? '0 : r_cx;
        ry   = fs ? '0 : r_ry;
        bx   = fs ? '0 : r_bx;
        by   = fs ? '0 : r_by;
        base = fs ? '0 : r_base;

        in_region = (g_bw != '0) && (g_bh != '0) && (bx < g_gx) && (by < g_gy);
        cx_end    = (cx == g_bw - 1'b1);
        ry_end    = (ry == g_bh - 1'b1);

        o_item.frame_start = fs;
        o_item.acc         = in_region;
        o_item.emit        = in_region && cx_end && ry_end;
        o_item.bx          = BX_W'(bx);
        o_item.pix         = PIX_SUM_W'(i_pix.data.chan_a) + PIX_SUM_W'(i_pix.data.chan_b)
                           + PIX_SUM_W'(i_pix.data.chan_c);
        o_item.block_index = base + INDEX_W'(bx);
        o_item.last_block  = (bx == g_gx - 1'b1) && (by == g_gy - 1'b1);

        n_col  = col;
        n_cx   = cx;
        n_ry   = ry;
        n_bx   = bx;
        n_by   = by;
        n_base = base;
        if (col == g_fw - 1'b1) begin
            n_col = '0;
            n_cx  = '0;
            n_bx  = '0;
            if (ry_end) begin
                n_ry = '0;
                if (by < g_gy) begin
                    n_by   = by + 1'b1;
                    n_base = base + INDEX_W'(g_gx);
                end
            end else begin
                n_ry = ry + 1'b1;
            end
        end else begin
            n_col = col + 1'b1;
            if (bx < g_gx) begin
                if (cx_end) begin
                    n_cx = '0;
                    n_bx = bx + 1'b1;
                end else begin
                    n_cx = cx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot <= 1'b1;
            r_col  <= '0;
            r_cx   <= '0;
            r_ry   <= '0;
            r_bx   <= '0;
            r_by   <= '0;
            r_base <= '0;
        end else begin
            if ((r_boot && i_status.done) || (take && fs)) begin
                r_boot  <= 1'b0;
                r_fw    <= i_fw;
                r_bw    <= i_bw;
                r_bh    <= i_bh;
                r_gx    <= i_gx;
                r_gy    <= i_gy;
                r_level <= i_level;
            end
            if (take) begin
                r_col  <= n_col;
                r_cx   <= n_cx;
                r_ry   <= n_ry;
                r_bx   <= n_bx;
                r_by   <= n_by;
                r_base <= n_base;
            end
        end
    end

    assign o_push  = take;
    assign o_level = r_level;

    a_region_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && o_item.acc) |-> (cx < g_bw) && (ry < g_bh))
        else $error("pixel placed outside its block");

endmodule

>>> design/gmbt_queue.sv
// ============================================================================
// gmbt_queue
// Short register FIFO of classified pixels between front and back.
// ============================================================================
module gmbt_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gmbt_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output gmbt_pkg::t_item o_item
);
    import gmbt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_item;
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("request pushed into a full queue");

endmodule

>>> design/gmbt_back.sv
// ============================================================================
// gmbt_back
// Column accumulators, block decision and the output register.
// ============================================================================
module gmbt_back #(
    parameter int MAX_IMAGE_DIM     = gmbt_pkg::MAX_IMAGE_DIM_DEF,
    parameter int MAX_BLOCKS_ACROSS = gmbt_pkg::MAX_BLOCKS_ACROSS_DEF,
    parameter int MAX_BLOCKS_DOWN   = gmbt_pkg::MAX_BLOCKS_DOWN_DEF,
    localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1),
    localparam int LEV_W = gmbt_pkg::CUTOFF_W + 2 * DIM_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  gmbt_pkg::t_item  i_item,
    input  logic [LEV_W-1:0] i_level,
    output logic             o_pop,
    gmbt_stream_if.source    o_bit
);
    import gmbt_pkg::*;

    localparam int IX_W = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;

    // decision level of the register defaults, used until the first frame start
    localparam longint RST_BW = longint'(clamp_range(RESET_IMAGE_WIDTH, MAX_IMAGE_DIM)
                                / clamp_range(RESET_BLOCKS_ACROSS, MAX_BLOCKS_ACROSS));
    localparam longint RST_BH = longint'(clamp_range(RESET_IMAGE_HEIGHT, MAX_IMAGE_DIM)
                                / clamp_range(RESET_BLOCKS_DOWN, MAX_BLOCKS_DOWN));
    localparam logic [LEV_W-1:0] RST_LEVEL = LEV_W'(longint'(RESET_CUTOFF) * RST_BW * RST_BH);

    logic [LEV_W-1:0] r_sum [MAX_BLOCKS_ACROSS];
    logic             r_ov;
    t_bit_out         r_out;
    logic [LEV_W-1:0] r_level;

    logic [IX_W-1:0]  ix;
    logic [LEV_W-1:0] n_sum;
    logic [LEV_W-1:0] lvl;

    assign ix    = i_item.bx[IX_W-1:0];
    assign o_pop = i_q_valid && (!i_item.emit || !r_ov || o_bit.ready);
    assign n_sum = (i_item.frame_start ? '0 : r_sum[ix]) + LEV_W'(i_item.pix);
    // the front's level belongs to the newest frame start; while an older
    // frame drains from the queue its own level is held here
    assign lvl   = i_item.frame_start ? i_level : r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_level <= RST_LEVEL;
            for (int i = 0; i < MAX_BLOCKS_ACROSS; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (r_ov && o_bit.ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop) begin
                if (i_item.frame_start) begin
                    r_level <= i_level;
                    for (int i = 0; i < MAX_BLOCKS_ACROSS; i++) begin
                        r_sum[i] <= '0;
                    end
                end
                if (i_item.acc) begin
                    // a finished block restarts its column accumulator
                    r_sum[ix] <= i_item.emit ? '0 : n_sum;
                end
                if (i_item.emit) begin
                    r_ov                <= 1'b1;
                    r_out.bit_value     <= (n_sum > lvl);
                    r_out.block_index   <= i_item.block_index;
                    r_out.last_block    <= i_item.last_block;
                end
            end
        end
    end

    assign o_bit.valid = r_ov;
    assign o_bit.data  = r_out;

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_bit.ready) |-> !(o_pop && i_item.emit))
        else $error("new result would overwrite an undelivered one");

endmodule

>>> design/grid_block_mean_threshold.sv
// ============================================================================
// grid_block_mean_threshold
// Per-block channel-mean threshold over a raster pixel stream.
// ============================================================================
// Usage:
//   i_pix carries one pixel per request (frame_start, chan_a/b/c) in raster
//   order; o_bit carries one request per finished grid block (bit_value,
//   block_index, last_block) in row-major block order. Both channels are
//   valid/ready.
//   Registers are to be written on i_cfg_we with i_cfg_addr/i_cfg_data only
//   while the block is idle; the block does not enforce this. They take effect
//   at the next frame_start pixel. Throughput: one pixel per clock while the
//   geometry unit is ready and the queue is not full. After a register write
//   the geometry unit recomputes the block size (a bit-serial divider, one
//   quotient bit per cycle over the dimension width) and the decision level
//   (registered multiplies); pixels are held off meanwhile. The same
//   computation runs once after reset. A block's bottom-right pixel is first
//   written into the queue; its result is then registered in the output register.
//   Reset clears the counters, the column sums and restores the register
//   defaults. When the receiver stalls, one result waits in the output
//   register and the 4-deep queue keeps taking pixels until it fills.
// ============================================================================
module grid_block_mean_threshold #(
    parameter int MAX_IMAGE_DIM     = gmbt_pkg::MAX_IMAGE_DIM_DEF,
    parameter int MAX_BLOCKS_ACROSS = gmbt_pkg::MAX_BLOCKS_ACROSS_DEF,
    parameter int MAX_BLOCKS_DOWN   = gmbt_pkg::MAX_BLOCKS_DOWN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gmbt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [gmbt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gmbt_stream_if.sink                     i_pix,
    gmbt_stream_if.source                   o_bit
);
    import gmbt_pkg::*;

    localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
    localparam int GX_W  = $clog2(MAX_BLOCKS_ACROSS + 1);
    localparam int GY_W  = $clog2(MAX_BLOCKS_DOWN + 1);
    localparam int LEV_W = CUTOFF_W + 2 * DIM_W;

    t_geom_status     geom_status;
    logic [DIM_W-1:0] geom_fw, geom_bw, geom_bh;
    logic [GX_W-1:0]  geom_gx;
    logic [GY_W-1:0]  geom_gy;
    logic [LEV_W-1:0] geom_level, act_level;

    logic  q_push, q_pop, q_full, q_valid;
    t_item push_item, head_item;

    gmbt_geom #(
        .MAX_IMAGE_DIM     (MAX_IMAGE_DIM),
        .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS),
        .MAX_BLOCKS_DOWN   (MAX_BLOCKS_DOWN)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_status   (geom_status),
        .o_fw       (geom_fw),
        .o_bw       (geom_bw),
        .o_bh       (geom_bh),
        .o_gx       (geom_gx),
        .o_gy       (geom_gy),
        .o_level    (geom_level)
    );

    gmbt_front #(
        .MAX_IMAGE_DIM     (MAX_IMAGE_DIM),
        .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS),
        .MAX_BLOCKS_DOWN   (MAX_BLOCKS_DOWN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_status (geom_status),
        .i_fw     (geom_fw),
        .i_bw     (geom_bw),
        .i_bh     (geom_bh),
        .i_gx     (geom_gx),
        .i_gy     (geom_gy),
        .i_level  (geom_level),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (push_item),
        .o_level  (act_level)
    );

    gmbt_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    gmbt_back #(
        .MAX_IMAGE_DIM     (MAX_IMAGE_DIM),
        .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS),
        .MAX_BLOCKS_DOWN   (MAX_BLOCKS_DOWN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (head_item),
        .i_level   (act_level),
        .o_pop     (q_pop),
        .o_bit     (o_bit)
    );

endmodule

>>> tb/tb_grid_block_mean_threshold.sv
// ============================================================================
// tb_grid_block_mean_threshold
// Self-checking bench for the grid block mean threshold block. A directed
// table covers reset geometry, 1x1 grids at the cutoff edges, zero and
// oversized registers, sub-pixel blocks and a small 2x2 grid. Random phases
// follow, each with new register settings and whole, cut-short or overlong
// frames. Both channel ends idle in random bursts. Every result is checked
// against an in-bench model of the block or against a result typed into the row.
// ============================================================================
module tb_grid_block_mean_threshold;
    timeunit 1ns;
    timeprecision 1ps;
    import gmbt_pkg::*;

    localparam int RAND_PIXELS      = 930;
    localparam int SETTLE_CYCLES    = 16;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int MAX_FRAME_PIXELS = 240;

    typedef enum {ROW_WRITE, ROW_PIXEL} t_row_op;

    typedef struct {
        t_row_op                op;
        t_cfg_index             idx;
        logic [CFG_DATA_W-1:0]  val;
        t_pix_in                pix;
        bit                     typed;    // result typed into the row
        bit                     has_res;
        t_bit_out               res;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gmbt_stream_if #(.T(t_pix_in))  pix_ch ();
    gmbt_stream_if #(.T(t_bit_out)) bit_ch ();

    grid_block_mean_threshold dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_bit      (bit_ch)
    );

    // ---------------- block model ----------------
    logic [DIM_REG_W-1:0]  reg_w, reg_h;
    logic [GRID_REG_W-1:0] reg_across, reg_down;
    logic [CUTOFF_W-1:0]   reg_cut;

    int unsigned     frm_w, frm_h, grid_x, grid_y, blk_w, blk_h;
    longint unsigned level;
    longint unsigned col_sum [MAX_BLOCKS_ACROSS_DEF];
    int unsigned     pix_col, pix_row;

    t_bit_out bits_due [$];
    t_dir_row plan [$];
    int       errors;
    bit       quiet;
    bit       gaps_on;
    bit       rx_idle_en;
    bit       dirty;
    int unsigned cycles;

    function automatic void expect_bit(input t_bit_out r);
        bits_due.insert(bits_due.size(), r);
    endfunction

    function automatic void add_row(input t_dir_row r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic int unsigned limit_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void latch_frame_geometry();
        frm_w  = limit_dim(reg_w, MAX_IMAGE_DIM_DEF);
        frm_h  = limit_dim(reg_h, MAX_IMAGE_DIM_DEF);
        grid_x = limit_dim(reg_across, MAX_BLOCKS_ACROSS_DEF);
        grid_y = limit_dim(reg_down, MAX_BLOCKS_DOWN_DEF);
        blk_w  = frm_w / grid_x;
        blk_h  = frm_h / grid_y;
        level  = longint'(reg_cut) * longint'(blk_w) * longint'(blk_h);
    endfunction

    // advances the model by one pixel; returns 1 when a block finishes
    function automatic bit predict_block_bit(input t_pix_in p, output t_bit_out r);
        int unsigned col, row, bx, by;
        bit got;
        got = 0;
        r   = '0;
        if (p.frame_start) begin
            pix_col = 0;
            pix_row = 0;
            foreach (col_sum[i]) col_sum[i] = 0;
            latch_frame_geometry();
        end
        col = pix_col;
        row = pix_row;
        if (blk_w != 0 && blk_h != 0 && row < frm_h &&
            col < blk_w * grid_x && row < blk_h * grid_y) begin
            bx = col / blk_w;
            by = row / blk_h;
            col_sum[bx] += longint'(p.chan_a) + longint'(p.chan_b) + longint'(p.chan_c);
            if (col % blk_w == blk_w - 1 && row % blk_h == blk_h - 1) begin
                r.bit_value   = col_sum[bx] > level;
                r.block_index = INDEX_W'((by * grid_x + bx) & 32'hFF);
                r.last_block  = (bx == grid_x - 1) && (by == grid_y - 1);
                col_sum[bx]   = 0;
                got           = 1;
            end
        end
        // row counter stops at the frame height
        if (row < frm_h) begin
            if (col + 1 >= frm_w) begin
                pix_col = 0;
                pix_row = row + 1;
            end else begin
                pix_col = col + 1;
            end
        end
        return got;
    endfunction

    // ---------------- directed rows ----------------
    function automatic t_dir_row row_wr(t_cfg_index idx, int v);
        t_dir_row r;
        r.op = ROW_WRITE; r.idx = idx; r.val = CFG_DATA_W'(v);
        r.pix = '0; r.typed = 0; r.has_res = 0; r.res = '0;
        return r;
    endfunction

    function automatic t_dir_row row_px(bit fs, int a, int b, int c);
        t_dir_row r;
        r.op = ROW_PIXEL; r.idx = CFG_IMAGE_WIDTH; r.val = '0;
        r.pix.frame_start = fs;
        r.pix.chan_a = CHAN_W'(a); r.pix.chan_b = CHAN_W'(b); r.pix.chan_c = CHAN_W'(c);
        r.typed = 0; r.has_res = 0; r.res = '0;
        return r;
    endfunction

    function automatic t_dir_row row_px_none(bit fs, int a, int b, int c);
        t_dir_row r;
        r = row_px(fs, a, b, c);
        r.typed = 1;
        return r;
    endfunction

    // single-block grid: index 0, always the last block
    function automatic t_dir_row row_px_bit(bit fs, int a, int b, int c, bit bv);
        t_dir_row r;
        r = row_px(fs, a, b, c);
        r.typed   = 1;
        r.has_res = 1;
        r.res     = '{bit_value: bv, block_index: '0, last_block: 1'b1};
        return r;
    endfunction

    function automatic t_pix_in rand_pixel(bit fs, int lo, int hi);
        t_pix_in p;
        p.frame_start = fs;
        p.chan_a = CHAN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(lo, hi));
        p.chan_b = CHAN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(lo, hi));
        p.chan_c = CHAN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(lo, hi));
        return p;
    endfunction

    // occasionally sets data bits above the register width
    function automatic logic [CFG_DATA_W-1:0] with_junk(int v, int bits);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'(v);
        if ($urandom_range(0, 7) == 0) d = d | CFG_DATA_W'($urandom() << bits);
        return d;
    endfunction

    // ---------------- sender side ----------------
    // all tasks enter and leave at a falling edge
    task automatic put_pixel(input t_pix_in p, input bit typed, input bit typed_has,
                             input t_bit_out typed_res);
        t_bit_out r;
        bit got;
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= p;
        do @(posedge i_clk); while (!pix_ch.ready);
        got = predict_block_bit(p, r);
        if (typed) begin
            if (typed_has) expect_bit(typed_res);
        end else if (got) begin
            expect_bit(r);
        end
        dirty = 1;
        @(negedge i_clk);
    endtask

    task automatic pixel_gap(input int n);
        pix_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic hold_pixels();
        pix_ch.valid <= 1'b0;
        do @(negedge i_clk); while (bits_due.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        if (dirty) begin
            // a pixel with no result may still be in flight
            hold_pixels();
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            dirty = 0;
        end
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:   reg_w      = val[DIM_REG_W-1:0];
            CFG_IMAGE_HEIGHT:  reg_h      = val[DIM_REG_W-1:0];
            CFG_BLOCKS_ACROSS: reg_across = val[GRID_REG_W-1:0];
            CFG_BLOCKS_DOWN:   reg_down   = val[GRID_REG_W-1:0];
            CFG_CUTOFF:        reg_cut    = val[CUTOFF_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic maybe_gap();
        if (gaps_on && !quiet && $urandom_range(0, 4) == 0) pixel_gap($urandom_range(1, 8));
    endtask

    // ---------------- clock, receiver, checker, watchdog ----------------
    always #1 i_clk = ~i_clk;

    int stall_left;
    always @(negedge i_clk) begin
        if (quiet) begin
            bit_ch.ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left != 0) begin
            bit_ch.ready <= 1'b0;
            stall_left--;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            bit_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            bit_ch.ready <= 1'b1;
        end
    end

    task automatic report_bad(input string what, input t_bit_out want, input t_bit_out got);
        errors++;
        if (errors <= 10)
            $display("%s: expected bit=%0d idx=%0d last=%0d, got bit=%0d idx=%0d last=%0d",
                     what, want.bit_value, want.block_index, want.last_block,
                     got.bit_value, got.block_index, got.last_block);
    endtask

    always @(posedge i_clk) begin
        t_bit_out got, want;
        if (i_rst_n && bit_ch.valid && bit_ch.ready) begin
            got = bit_ch.data;
            if (bits_due.size() == 0) begin
                report_bad("block bit with none pending", '0, got);
            end else begin
                want = bits_due.pop_front();
                if (got.bit_value !== want.bit_value || got.block_index !== want.block_index ||
                    got.last_block !== want.last_block)
                    report_bad("block bit mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_grid_block_mean_threshold: done, errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        t_pix_in     p;
        int unsigned sent, npix, w, h, ac, dn, cut, lo, hi, nfr;
        bit          drained;

        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = CFG_IMAGE_WIDTH;
        i_cfg_data   = '0;
        pix_ch.valid = 1'b0;
        pix_ch.data  = '0;
        bit_ch.ready = 1'b0;
        stall_left   = 0;
        errors       = 0;
        cycles       = 0;
        quiet        = 0;
        gaps_on      = 1;
        rx_idle_en   = 1;
        dirty        = 0;
        drained      = 0;
        sent         = 0;

        reg_w      = RESET_IMAGE_WIDTH;
        reg_h      = RESET_IMAGE_HEIGHT;
        reg_across = RESET_BLOCKS_ACROSS;
        reg_down   = RESET_BLOCKS_DOWN;
        reg_cut    = RESET_CUTOFF;
        foreach (col_sum[i]) col_sum[i] = 0;
        pix_col = 0;
        pix_row = 0;
        latch_frame_geometry();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry is 64x60 blocks: nothing finishes this early
        add_row(row_px_none(1, 0, 0, 0));
        add_row(row_px_none(0, 255, 255, 255));
        // 1x1 grid of one pixel, cutoff on either side of full white
        add_row(row_wr(CFG_IMAGE_WIDTH, 1));
        add_row(row_wr(CFG_IMAGE_HEIGHT, 1));
        add_row(row_wr(CFG_BLOCKS_ACROSS, 1));
        add_row(row_wr(CFG_BLOCKS_DOWN, 1));
        add_row(row_wr(CFG_CUTOFF, 764));
        add_row(row_px_bit(1, 255, 255, 255, 1));
        add_row(row_px_bit(1, 255, 255, 254, 0));
        add_row(row_px_none(0, 255, 255, 255));   // past the last row
        add_row(row_wr(CFG_CUTOFF, 0));
        add_row(row_px_bit(1, 0, 0, 0, 0));
        add_row(row_px_bit(1, 1, 0, 0, 1));
        add_row(row_wr(CFG_CUTOFF, 1023));
        add_row(row_px_bit(1, 255, 255, 255, 0));
        // zero registers read as one
        add_row(row_wr(CFG_IMAGE_WIDTH, 0));
        add_row(row_wr(CFG_IMAGE_HEIGHT, 0));
        add_row(row_wr(CFG_BLOCKS_ACROSS, 0));
        add_row(row_wr(CFG_BLOCKS_DOWN, 0));
        add_row(row_wr(CFG_CUTOFF, 0));
        add_row(row_px_bit(1, 0, 128, 0, 1));
        // image narrower than the grid: zero-width blocks
        add_row(row_wr(CFG_IMAGE_WIDTH, 2));
        add_row(row_wr(CFG_BLOCKS_ACROSS, 4));
        add_row(row_px_none(1, 255, 255, 255));
        add_row(row_px_none(0, 255, 255, 255));
        // oversized registers saturate
        add_row(row_wr(CFG_IMAGE_WIDTH, 8191));
        add_row(row_wr(CFG_IMAGE_HEIGHT, 8191));
        add_row(row_wr(CFG_BLOCKS_ACROSS, 31));
        add_row(row_wr(CFG_BLOCKS_DOWN, 31));
        add_row(row_wr(CFG_CUTOFF, 765));
        add_row(row_px(1, 200, 100, 50));
        add_row(row_px(0, 7, 8, 9));
        // 4x2 image as a 2x2 grid of 2x1 blocks
        add_row(row_wr(CFG_IMAGE_WIDTH, 4));
        add_row(row_wr(CFG_IMAGE_HEIGHT, 2));
        add_row(row_wr(CFG_BLOCKS_ACROSS, 2));
        add_row(row_wr(CFG_BLOCKS_DOWN, 2));
        add_row(row_wr(CFG_CUTOFF, 100));
        add_row(row_px(1, 10, 20, 30));
        add_row(row_px(0, 40, 50, 60));
        add_row(row_px(0, 50, 50, 0));
        add_row(row_px(0, 50, 50, 0));
        add_row(row_px(0, 255, 255, 255));
        add_row(row_px(0, 255, 255, 255));
        add_row(row_px(0, 1, 2, 3));
        add_row(row_px(0, 4, 5, 6));
        add_row(row_px(0, 99, 99, 99));

        foreach (plan[i]) begin
            if (plan[i].op == ROW_WRITE) begin
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                maybe_gap();
                put_pixel(plan[i].pix, plan[i].typed, plan[i].has_res, plan[i].res);
            end
        end

        while (sent < RAND_PIXELS) begin
            if ($urandom_range(0, 15) == 0) begin
                w  = $urandom_range(0, 8191);
                h  = $urandom_range(0, 8191);
                ac = $urandom_range(0, 31);
                dn = $urandom_range(0, 31);
            end else begin
                w  = $urandom_range(1, 20);
                h  = $urandom_range(1, 10);
                ac = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(1, (w < 16) ? w : 16);
                dn = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(1, (h < 16) ? h : 16);
            end
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(200, 560);
            write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
            write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            write_reg(CFG_BLOCKS_ACROSS, with_junk(ac, GRID_REG_W));
            write_reg(CFG_BLOCKS_DOWN, with_junk(dn, GRID_REG_W));
            write_reg(CFG_CUTOFF, with_junk(cut, CUTOFF_W));
            gaps_on    = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);

            // new registers must not touch the frame already under way
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    put_pixel(rand_pixel(0, 0, 255), 0, 0, '0);
                    sent++;
                end
            end

            nfr = $urandom_range(1, 3);
            for (int f = 0; f < nfr && sent < RAND_PIXELS; f++) begin
                npix = limit_dim(reg_w, MAX_IMAGE_DIM_DEF) * limit_dim(reg_h, MAX_IMAGE_DIM_DEF);
                if (npix > MAX_FRAME_PIXELS) npix = $urandom_range(1, MAX_FRAME_PIXELS);
                case ($urandom_range(0, 7))
                    0: npix = $urandom_range(1, npix);       // cut short
                    1: npix = npix + $urandom_range(1, 5);   // runs past the end
                    default: ;
                endcase
                lo = $urandom_range(0, 255);
                hi = $urandom_range(lo, 255);
                for (int k = 0; k < npix && sent < RAND_PIXELS; k++) begin
                    if (!drained && k == npix / 2) begin
                        hold_pixels();
                        drained = 1;
                    end else if (!quiet && $urandom_range(0, 63) == 0) begin
                        hold_pixels();
                    end
                    maybe_gap();
                    p = rand_pixel(k == 0, lo, hi);
                    put_pixel(p, 0, 0, '0);
                    sent++;
                    quiet = (sent >= RAND_PIXELS * 4 / 5);
                end
            end
        end

        hold_pixels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && bits_due.size() == 0) begin
            $display("tb_grid_block_mean_threshold: done, clean");
        end else begin
            $display("tb_grid_block_mean_threshold: done, errors");
        end
        $finish;
    end

endmodule
